// ===== src/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// SM3 compression package
// Shared constants and round helper functions for the SM3 compression core.
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned QDepth   = 2;

  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;

  localparam logic [31:0] IvReset [NumRegs] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef logic [31:0] word_t;

  // One message word handed from the front to the back.
  typedef struct packed {
    word_t word;
    logic  first;   // word opens a new message
    logic  last;    // sixteenth word of a block
  } q_item_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} << r;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// ===== src/sm3_front.sv =====
// ----------------------------------------------------------------------------
// SM3 front end
// Accepts message words, tracks the word position in the block and pushes
// tagged words into a short queue toward the round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_front
  import sm3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire word_t   in_msg_word,
  input  wire logic    in_begins_message,
  output logic         q_valid,
  input  wire logic    q_ready,
  output q_item_t      q_item
);

  q_item_t    mem_r [QDepth];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [3:0] pos_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{word: in_msg_word,
                       first: in_begins_message && (pos_r == 4'd0),
                       last: (pos_r == 4'd15)};
    end
  end

  // pointers and word position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; pos_r <= '0;
    end else begin
      if (push) begin
        wp_r  <= wp_r + 1'b1;
        pos_r <= pos_r + 4'd1;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDepth)) else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count");
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pos_r == 4'd15) |=> pos_r == 4'd0) else $error("position wrap");
`endif

endmodule
`default_nettype wire

// ===== src/sm3_back.sv =====
// ----------------------------------------------------------------------------
// SM3 round engine
// Collects a block, runs 64 rounds one per cycle with a 16-word rolling
// message schedule, folds into the chaining value and emits eight words.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_back
  import sm3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire word_t   cfg_data,
  input  wire logic    q_valid,
  output logic         q_ready,
  input  wire q_item_t q_item,
  output logic         out_valid,
  input  wire logic    out_ready,
  output word_t        out_digest_word,
  output logic [2:0]   out_word_index,
  output logic         out_last_word
);

  typedef enum logic [1:0] {S_LOAD, S_ROUND, S_EMIT} state_t;

  state_t     state_r;
  word_t      iv_r [NumRegs];
  word_t      cv_r [NumRegs];
  word_t      v_r  [NumRegs];
  word_t      w_r  [BlkWords];
  logic [5:0] rnd_r;
  logic [2:0] oidx_r;

  logic  high;
  word_t t_rot, a12, ss1, ss2, ff, gg, tt1, tt2, wnew, wp;

  // round datapath
  always_comb begin
    high  = rnd_r[5] | rnd_r[4];
    t_rot = rotl(high ? THigh : TLow, rnd_r[4:0]);
    a12   = rotl(v_r[0], 5'd12);
    ss1   = rotl(a12 + v_r[4] + t_rot, 5'd7);
    ss2   = ss1 ^ a12;
    ff    = high ? ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]))
                 : (v_r[0] ^ v_r[1] ^ v_r[2]);
    gg    = high ? ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]))
                 : (v_r[4] ^ v_r[5] ^ v_r[6]);
    wnew  = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15))
            ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    wp    = w_r[0] ^ w_r[4];
    tt1   = ff + v_r[3] + ss2 + wp;
    tt2   = gg + v_r[7] + ss1 + w_r[0];
  end

  assign q_ready         = (state_r == S_LOAD);
  assign out_valid       = (state_r == S_EMIT);
  assign out_digest_word = cv_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) iv_r[i] <= IvReset[i];
    end else if (cfg_we) begin
      iv_r[cfg_index] <= cfg_data;
    end
  end

  // sequencer, schedule window and working variables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rnd_r   <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < NumRegs; i++) cv_r[i] <= IvReset[i];
    end else begin
      case (state_r)
        S_LOAD: begin
          if (q_valid) begin
            for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= w_r[i+1];
            w_r[BlkWords-1] <= q_item.word;
            if (q_item.first) begin
              for (int i = 0; i < NumRegs; i++) cv_r[i] <= iv_r[i];
            end
            if (q_item.last) begin
              for (int i = 0; i < NumRegs; i++) v_r[i] <= cv_r[i];
              if (q_item.first) begin
                for (int i = 0; i < NumRegs; i++) v_r[i] <= iv_r[i];
              end
              rnd_r   <= '0;
              state_r <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          for (int i = 0; i < BlkWords - 1; i++) w_r[i] <= w_r[i+1];
          w_r[BlkWords-1] <= wnew;
          v_r[0] <= tt1;
          v_r[1] <= v_r[0];
          v_r[2] <= rotl(v_r[1], 5'd9);
          v_r[3] <= v_r[2];
          v_r[4] <= perm0(tt2);
          v_r[5] <= v_r[4];
          v_r[6] <= rotl(v_r[5], 5'd19);
          v_r[7] <= v_r[6];
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'(Rounds - 1)) begin
            state_r <= S_EMIT;
            oidx_r  <= '0;
            cv_r[0] <= cv_r[0] ^ tt1;
            cv_r[1] <= cv_r[1] ^ v_r[0];
            cv_r[2] <= cv_r[2] ^ rotl(v_r[1], 5'd9);
            cv_r[3] <= cv_r[3] ^ v_r[2];
            cv_r[4] <= cv_r[4] ^ perm0(tt2);
            cv_r[5] <= cv_r[5] ^ v_r[4];
            cv_r[6] <= cv_r[6] ^ rotl(v_r[5], 5'd19);
            cv_r[7] <= cv_r[7] ^ v_r[6];
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_round_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'd63) |=> (state_r == S_EMIT && oidx_r == 3'd0))
    else $error("round end");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_digest_word) && $stable(oidx_r))
    else $error("emit hold");
  a_no_pull: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> !q_ready) else $error("pull while busy");
`endif

endmodule
`default_nettype wire

// ===== src/sm3_compression_core_top.sv =====
// The sixteen words of a block load one per cycle while the queue and the
// engine take them; the engine then runs 64 rounds and emits eight digest
// words. The sixteenth word passes through the queue register into the round
// engine before the rounds start. The engine takes no new word until its last
// digest word is taken; meanwhile further message words wait in the queue.
// Reset: synchronous active-low rst_n; IV registers and chaining value take
// the standard SM3 IV, word position clears to zero.
// ----------------------------------------------------------------------------
// SM3 compression core top
// Front end queue feeding the SM3 round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_compression_core_top
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_msg_word,
  input  wire logic        in_begins_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  logic    q_valid, q_ready;
  q_item_t q_item;

  sm3_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_msg_word, .in_begins_message,
    .q_valid, .q_ready, .q_item
  );

  sm3_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule
`default_nettype wire

// ===== tb/sm3_compression_checker.sv =====
// ----------------------------------------------------------------------------
// SM3 compression checker
// Watches the message word and digest word channels, keeps its own SM3
// compression state, predicts the eight digest words of each block and
// compares every accepted digest word with the oldest prediction.
// ----------------------------------------------------------------------------
module sm3_compression_checker
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_msg_word,
  input  logic        in_begins_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_digests
);

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic [31:0] iv_shadow [8];
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [3:0]  word_pos;
  digest_exp_t digest_q [$];

  assign pending_digests = digest_q.size();

  function automatic logic [31:0] rol(logic [31:0] x, int r);
    r = r & 31;
    if (r == 0) return x;
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] p0f(logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] p1f(logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // Run the 64 rounds on the collected block and fold into the chain
  task automatic compress_and_queue();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, t;
    digest_exp_t x;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int j = 0; j < 64; j++) begin
      t   = (j >= 16) ? THigh : TLow;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(t, j), 7);
      ss2 = ss1 ^ a12;
      ff  = (j >= 16) ? ((a & b) | (a & c) | (b & c)) : (a ^ b ^ c);
      gg  = (j >= 16) ? ((e & f) | (~e & g)) : (e ^ f ^ g);
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = p0f(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    for (int k = 0; k < 8; k++) begin
      x.digest = chain[k];
      x.idx    = 3'(k);
      x.last   = (k == 7);
      digest_q.push_back(x);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    digest_exp_t x;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        iv_shadow[i] = IvReset[i];
        chain[i]     = IvReset[i];
      end
      word_pos = '0;
      digest_q.delete();
    end else begin
      if (cfg_we) iv_shadow[cfg_index] = cfg_data;
      // message word accepted
      if (in_valid && in_ready) begin
        if (in_begins_message && word_pos == 0)
          for (int i = 0; i < 8; i++) chain[i] = iv_shadow[i];
        blk[word_pos] = in_msg_word;
        word_pos = word_pos + 1;
        if (word_pos == 0) compress_and_queue();
      end
      // digest word accepted
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest word", out_digest_word, '0);
        end else begin
          x = digest_q.pop_front();
          if (out_digest_word !== x.digest) report("digest_word", out_digest_word, x.digest);
          if (out_word_index !== x.idx) report("word_index", 32'(out_word_index), 32'(x.idx));
          if (out_last_word !== x.last) report("last_word", 32'(out_last_word), 32'(x.last));
        end
      end
    end
  end

endmodule

// ===== tb/tb_sm3_compression_core_top.sv =====
// ----------------------------------------------------------------------------
// SM3 compression core testbench
// Feeds message blocks of fixed patterns and random content with message
// starts, rewrites the IV registers between phases, idles both channels at
// random, and takes the verdict from the checker beside the core.
// ----------------------------------------------------------------------------
module tb_sm3_compression_core_top;
  import sm3_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_msg_word;
  logic        in_begins_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          pending_digests;
  int          cycle_count;
  bit          calm;   // no idling in the closing part

  sm3_compression_core_top dut (.*);

  sm3_compression_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    int n;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1;
      end else begin
        n = $urandom_range(1, 18);
        out_ready <= 0;
        repeat (n) @(negedge clk);
        out_ready <= 1;
      end
    end
  end

  // one message word; holds valid until accepted
  // in_ready only moves at the rising edge, so its value at the falling edge
  // tells whether the coming edge takes the word
  task automatic send_word(logic [31:0] w, logic first);
    in_valid          <= 1;
    in_msg_word       <= w;
    in_begins_message <= first;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic send_block(int kind, logic first);
    logic [31:0] w;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: w = '0;
        1: w = '1;
        2: w = (i % 2) ? 32'haaaaaaaa : 32'h55555555;
        default: w = $urandom;
      endcase
      // flag on a later word must be ignored
      send_word(w, (i == 0) ? first : ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic drain_then_write(logic [31:0] vals [8]);
    in_valid <= 0;
    while (pending_digests != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 0;
  endtask

  initial begin
    logic [31:0] v [8];
    int wait_n;
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0; calm = 0;
    in_valid = 0; in_msg_word = '0; in_begins_message = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: no flag on the very first block uses the reset IV
    send_block(3, 0);
    send_block(0, 1);
    send_block(1, 0);
    send_block(2, 1);

    // all-zero IV
    foreach (v[i]) v[i] = '0;
    drain_then_write(v);
    send_block(3, 1);
    send_block(1, 0);

    // all-ones IV, then random IVs through the random phases
    for (int ph = 0; ph < 5; ph++) begin
      foreach (v[i]) v[i] = (ph == 0) ? '1 : $urandom;
      drain_then_write(v);
      if (ph == 4) calm = 1;
      for (int b = 0; b < 4; b++) begin
        send_block(3, $urandom_range(0, 2) == 0);
        // single register write between blocks, once the core is idle;
        // it only takes effect at the next message start
        if (b == 2 && ph == 1) begin
          while (pending_digests != 0) @(negedge clk);
          cfg_we <= 1; cfg_index <= 3'($urandom_range(0, 7)); cfg_data <= $urandom;
          @(negedge clk);
          cfg_we <= 0;
        end
      end
    end
    // restore standard IV for a final tail
    foreach (v[i]) v[i] = IvReset[i];
    drain_then_write(v);
    send_block(3, 1);
    send_block(3, 0);
    send_block(3, 0);
    send_word($urandom, 1);  // partial block, no result
    in_valid <= 0;

    wait_n = 0;
    while (pending_digests != 0 && wait_n < 20000) begin
      @(negedge clk);
      wait_n++;
    end
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_digests == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
